FILE: hdl/gspc_pkg.sv
// shared types and constants of the gate sound presence controller
package gspc_pkg;

	localparam int CFG_IDX_BITS  = 3;
	localparam int CFG_DATA_BITS = 16;

	localparam logic [CFG_IDX_BITS-1:0] REG_SOUND_THRESHOLD = 3'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_ECHO_LIMIT_US   = 3'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_LOCKOUT_MS      = 3'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_LED_HOLD_MS     = 3'd3;
	localparam logic [CFG_IDX_BITS-1:0] REG_BLINK_MS        = 3'd4;
	localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_STEP_MS    = 3'd5;
	localparam logic [CFG_IDX_BITS-1:0] REG_CLOSE_STEP_MS   = 3'd6;
	localparam logic [CFG_IDX_BITS-1:0] REG_OPEN_ANGLE      = 3'd7;

	localparam logic [9:0]  RST_SOUND_THRESHOLD = 10'd15;
	localparam logic [14:0] RST_ECHO_LIMIT_US   = 15'd1470;
	localparam logic [15:0] RST_LOCKOUT_MS      = 16'd3000;
	localparam logic [15:0] RST_LED_HOLD_MS     = 16'd5000;
	localparam logic [15:0] RST_BLINK_MS        = 16'd500;
	localparam logic [7:0]  RST_OPEN_STEP_MS    = 8'd30;
	localparam logic [7:0]  RST_CLOSE_STEP_MS   = 8'd15;
	localparam logic [7:0]  RST_OPEN_ANGLE      = 8'd120;

	typedef struct packed {
		logic [9:0]  sound_threshold;
		logic [14:0] echo_limit_us;
		logic [15:0] lockout_ms;
		logic [15:0] led_hold_ms;
		logic [15:0] blink_ms;
		logic [7:0]  open_step_ms;
		logic [7:0]  close_step_ms;
		logic [7:0]  open_angle;
	} cfg_t;

	typedef struct packed {
		logic       gate_is_open;
		logic       main_led;
		logic       amber_led;
		logic       red_led;
		logic       move_start;
		logic [7:0] move_target;
		logic [7:0] move_step_ms;
	} result_t;

endpackage

FILE: hdl/gspc_cfg_regs.sv
// configuration register file of the gate controller
module gspc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [gspc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [gspc_pkg::CFG_DATA_BITS-1:0] cfg_data,
	output gspc_pkg::cfg_t                     cfg
);
	import gspc_pkg::*;

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.sound_threshold <= RST_SOUND_THRESHOLD;
			cfg_q.echo_limit_us   <= RST_ECHO_LIMIT_US;
			cfg_q.lockout_ms      <= RST_LOCKOUT_MS;
			cfg_q.led_hold_ms     <= RST_LED_HOLD_MS;
			cfg_q.blink_ms        <= RST_BLINK_MS;
			cfg_q.open_step_ms    <= RST_OPEN_STEP_MS;
			cfg_q.close_step_ms   <= RST_CLOSE_STEP_MS;
			cfg_q.open_angle      <= RST_OPEN_ANGLE;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SOUND_THRESHOLD: cfg_q.sound_threshold <= cfg_data[9:0];
				REG_ECHO_LIMIT_US:   cfg_q.echo_limit_us   <= cfg_data[14:0];
				REG_LOCKOUT_MS:      cfg_q.lockout_ms      <= cfg_data;
				REG_LED_HOLD_MS:     cfg_q.led_hold_ms     <= cfg_data;
				REG_BLINK_MS:        cfg_q.blink_ms        <= cfg_data;
				REG_OPEN_STEP_MS:    cfg_q.open_step_ms    <= cfg_data[7:0];
				REG_CLOSE_STEP_MS:   cfg_q.close_step_ms   <= cfg_data[7:0];
				REG_OPEN_ANGLE:      cfg_q.open_angle      <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

FILE: hdl/gspc_core.sv
// per-poll decision logic and controller state
module gspc_core #(
	parameter int SAMPLE_BITS = 10,
	parameter int TIME_BITS   = 32
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   fire,
	input  logic [TIME_BITS-1:0]   now_ms,
	input  logic [SAMPLE_BITS-1:0] mic_sample,
	input  logic [14:0]            echo_us,
	input  gspc_pkg::cfg_t         cfg,
	output gspc_pkg::result_t      result
);
	import gspc_pkg::*;

	localparam int CMP_BITS = SAMPLE_BITS + 10;
	localparam int PROD_BITS = 17;
	localparam int SUM_BITS = TIME_BITS + PROD_BITS;

	logic [SAMPLE_BITS-1:0] prev_sample_q;
	logic                   gate_open_q, consumed_q, hold_pending_q, blink_en_q, amber_phase_q;
	logic                   main_q, amber_q, red_q;
	logic [TIME_BITS-1:0]   last_action_q, close_time_q, last_blink_q;

	logic                   gate_open_d, consumed_d, hold_pending_d, blink_en_d, amber_phase_d;
	logic                   main_d, amber_d, red_d;
	logic [TIME_BITS-1:0]   last_action_d, close_time_d, last_blink_d;

	logic [SAMPLE_BITS-1:0] diff;
	logic                   sound, presence, lock_ok, blink_due;
	logic [PROD_BITS-1:0]   ramp_ms;
	logic [SUM_BITS-1:0]    ramp_end;
	logic [TIME_BITS-1:0]   el_blink, el_action, el_close;

	assign diff = (mic_sample >= prev_sample_q) ? mic_sample - prev_sample_q
	                                            : prev_sample_q - mic_sample;
	assign sound = CMP_BITS'(diff) > CMP_BITS'(cfg.sound_threshold);
	assign presence = (echo_us != 15'd0) && (echo_us <= cfg.echo_limit_us);

	assign el_blink  = now_ms - last_blink_q;
	assign el_action = now_ms - last_action_q;
	assign el_close  = now_ms - close_time_q;
	assign blink_due = blink_en_q && (el_blink >= TIME_BITS'(cfg.blink_ms));
	assign lock_ok   = el_action > TIME_BITS'(cfg.lockout_ms);

	// end of the opening ramp: now + (angle+1) * step
	assign ramp_ms  = PROD_BITS'({1'b0, cfg.open_angle} + 9'd1) * PROD_BITS'(cfg.open_step_ms);
	assign ramp_end = SUM_BITS'(now_ms) + SUM_BITS'(ramp_ms);

	always_comb begin
		gate_open_d    = gate_open_q;
		consumed_d     = consumed_q;
		hold_pending_d = hold_pending_q;
		blink_en_d     = blink_en_q;
		amber_phase_d  = amber_phase_q;
		main_d         = main_q;
		amber_d        = amber_q;
		red_d          = red_q;
		last_action_d  = last_action_q;
		close_time_d   = close_time_q;
		last_blink_d   = last_blink_q;
		result         = '0;

		if (blink_due) begin
			last_blink_d  = now_ms;
			amber_d       = !amber_phase_q;
			red_d         = amber_phase_q;
			amber_phase_d = !amber_phase_q;
		end

		if (!gate_open_q && sound && presence && !consumed_q && lock_ok) begin
			main_d              = 1'b1;
			blink_en_d          = 1'b1;
			result.move_start   = 1'b1;
			result.move_target  = cfg.open_angle;
			result.move_step_ms = cfg.open_step_ms;
			gate_open_d         = 1'b1;
			last_action_d       = ramp_end[TIME_BITS-1:0];
			consumed_d          = 1'b1;
		end else if (gate_open_q && sound && !consumed_q && lock_ok) begin
			result.move_start   = 1'b1;
			result.move_step_ms = cfg.close_step_ms;
			gate_open_d         = 1'b0;
			last_action_d       = now_ms;
			close_time_d        = now_ms;
			hold_pending_d      = 1'b1;
			consumed_d          = 1'b1;
			blink_en_d          = 1'b0;
			amber_d             = 1'b0;
			red_d               = 1'b0;
		end

		// close_time is unchanged or equal to now, so el_close stays valid
		if (!gate_open_d && hold_pending_d &&
		    ((close_time_d == now_ms ? '0 : el_close) > TIME_BITS'(cfg.led_hold_ms))) begin
			main_d         = 1'b0;
			hold_pending_d = 1'b0;
		end

		if (!sound)
			consumed_d = 1'b0;

		result.gate_is_open = gate_open_d;
		result.main_led     = main_d;
		result.amber_led    = amber_d;
		result.red_led      = red_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_sample_q  <= '0;
			gate_open_q    <= 1'b0;
			consumed_q     <= 1'b0;
			hold_pending_q <= 1'b0;
			blink_en_q     <= 1'b0;
			amber_phase_q  <= 1'b0;
			main_q         <= 1'b0;
			amber_q        <= 1'b0;
			red_q          <= 1'b0;
			last_action_q  <= '0;
			close_time_q   <= '0;
			last_blink_q   <= '0;
		end else if (fire) begin
			prev_sample_q  <= mic_sample;
			gate_open_q    <= gate_open_d;
			consumed_q     <= consumed_d;
			hold_pending_q <= hold_pending_d;
			blink_en_q     <= blink_en_d;
			amber_phase_q  <= amber_phase_d;
			main_q         <= main_d;
			amber_q        <= amber_d;
			red_q          <= red_d;
			last_action_q  <= last_action_d;
			close_time_q   <= close_time_d;
			last_blink_q   <= last_blink_d;
		end
	end

endmodule

FILE: hdl/gate_sound_presence_controller.sv
// top level of the gate sound presence controller
// Each input transaction is one sensor poll; the block returns one result
// transaction per poll. Polls are registered, evaluated in a single pass of
// compare and wrapping-subtract logic that also updates the controller state,
// and the result is registered, so a poll can be accepted every cycle and its
// result is offered from the result register. The output register lets a new
// poll enter while a result waits; throughput drops only while the downstream
// side stalls. Configuration takes effect on the next poll.
module gate_sound_presence_controller #(
	parameter int SAMPLE_BITS = 10,
	parameter int TIME_BITS   = 32
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [TIME_BITS-1:0]               now_ms,
	input  logic [SAMPLE_BITS-1:0]             mic_sample,
	input  logic [14:0]                        echo_us,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               gate_is_open,
	output logic                               main_led,
	output logic                               amber_led,
	output logic                               red_led,
	output logic                               move_start,
	output logic [7:0]                         move_target,
	output logic [7:0]                         move_step_ms,
	input  logic                               cfg_we,
	input  logic [gspc_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [gspc_pkg::CFG_DATA_BITS-1:0] cfg_data
);
	import gspc_pkg::*;

	cfg_t    cfg;
	result_t step_res;
	result_t result_q;

	logic                   valid_s1;
	logic [TIME_BITS-1:0]   now_s1;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [14:0]            echo_s1;
	logic                   out_valid_q;
	logic                   out_free, advance, in_take;

	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	gspc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	gspc_core #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.TIME_BITS   (TIME_BITS)
	) u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.fire       (advance),
		.now_ms     (now_s1),
		.mic_sample (sample_s1),
		.echo_us    (echo_s1),
		.cfg        (cfg),
		.result     (step_res)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			now_s1    <= now_ms;
			sample_s1 <= mic_sample;
			echo_s1   <= echo_us;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance)
			result_q <= step_res;
	end

	assign out_valid    = out_valid_q;
	assign gate_is_open = result_q.gate_is_open;
	assign main_led     = result_q.main_led;
	assign amber_led    = result_q.amber_led;
	assign red_led      = result_q.red_led;
	assign move_start   = result_q.move_start;
	assign move_target  = result_q.move_target;
	assign move_step_ms = result_q.move_step_ms;

endmodule

FILE: tb/sv/gspc_checker.sv
// checker of the gate sound presence controller: predicts each poll result and compares
module gspc_checker
	import gspc_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	input  logic                     in_stall,
	input  logic [31:0]              now_ms,
	input  logic [9:0]               mic_sample,
	input  logic [14:0]              echo_us,
	input  logic                     out_valid,
	input  logic                     out_stall,
	input  logic                     gate_is_open,
	input  logic                     main_led,
	input  logic                     amber_led,
	input  logic                     red_led,
	input  logic                     move_start,
	input  logic [7:0]               move_target,
	input  logic [7:0]               move_step_ms,
	input  logic                     cfg_we,
	input  logic [CFG_IDX_BITS-1:0]  cfg_index,
	input  logic [CFG_DATA_BITS-1:0] cfg_data,
	output int                       mismatches,
	output int                       pending
);
	timeunit 1ns;
	timeprecision 1ps;

	cfg_t        regs;
	logic [9:0]  prev_mic;
	logic        gate_state, sound_used, hold_armed, blink_on, amber_next;
	logic        led_main, led_amber, led_red;
	logic [31:0] action_stamp, close_stamp, blink_stamp;

	result_t     expected_results[$];
	result_t     got, want;
	int          result_idx = 0;

	initial begin
		mismatches = 0;
		pending = 0;
	end

	task clear_state();
		regs.sound_threshold = RST_SOUND_THRESHOLD;
		regs.echo_limit_us   = RST_ECHO_LIMIT_US;
		regs.lockout_ms      = RST_LOCKOUT_MS;
		regs.led_hold_ms     = RST_LED_HOLD_MS;
		regs.blink_ms        = RST_BLINK_MS;
		regs.open_step_ms    = RST_OPEN_STEP_MS;
		regs.close_step_ms   = RST_CLOSE_STEP_MS;
		regs.open_angle      = RST_OPEN_ANGLE;
		prev_mic     = '0;
		gate_state   = 1'b0;
		sound_used   = 1'b0;
		hold_armed   = 1'b0;
		blink_on     = 1'b0;
		amber_next   = 1'b0;
		led_main     = 1'b0;
		led_amber    = 1'b0;
		led_red      = 1'b0;
		action_stamp = '0;
		close_stamp  = '0;
		blink_stamp  = '0;
	endtask

	// one poll: blink toggle, then open/close decision, then main led hold-off
	task predict_poll(input logic [31:0] t, input logic [9:0] m, input logic [14:0] e,
			output result_t r);
		logic [9:0] diff;
		logic       sound, presence, lock_ok;
		r = '0;
		diff = (m >= prev_mic) ? m - prev_mic : prev_mic - m;
		prev_mic = m;
		sound = diff > regs.sound_threshold;
		presence = (e != 15'd0) && (e <= regs.echo_limit_us);

		if (blink_on && (t - blink_stamp) >= {16'd0, regs.blink_ms}) begin
			blink_stamp = t;
			led_red = amber_next;
			led_amber = !amber_next;
			amber_next = !amber_next;
		end

		lock_ok = (t - action_stamp) > {16'd0, regs.lockout_ms};

		if (!gate_state && sound && presence && !sound_used && lock_ok) begin
			led_main = 1'b1;
			blink_on = 1'b1;
			r.move_start = 1'b1;
			r.move_target = regs.open_angle;
			r.move_step_ms = regs.open_step_ms;
			gate_state = 1'b1;
			// lockout runs from the end of the opening ramp
			action_stamp = t + ({24'd0, regs.open_angle} + 32'd1) * {24'd0, regs.open_step_ms};
			sound_used = 1'b1;
		end else if (gate_state && sound && !sound_used && lock_ok) begin
			r.move_start = 1'b1;
			r.move_target = 8'd0;
			r.move_step_ms = regs.close_step_ms;
			gate_state = 1'b0;
			action_stamp = t;
			close_stamp = t;
			hold_armed = 1'b1;
			sound_used = 1'b1;
			blink_on = 1'b0;
			led_amber = 1'b0;
			led_red = 1'b0;
		end

		if (!gate_state && hold_armed && (t - close_stamp) > {16'd0, regs.led_hold_ms}) begin
			led_main = 1'b0;
			hold_armed = 1'b0;
		end

		if (!sound)
			sound_used = 1'b0;

		r.gate_is_open = gate_state;
		r.main_led = led_main;
		r.amber_led = led_amber;
		r.red_led = led_red;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
			expected_results.delete();
			pending = 0;
		end else begin
			// compare before pushing so a result never meets its own poll
			if (out_valid && !out_stall) begin
				got = {gate_is_open, main_led, amber_led, red_led, move_start,
					move_target, move_step_ms};
				if (expected_results.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("result %0d arrived with no poll waiting", result_idx);
				end else begin
					want = expected_results.pop_front();
					if (got !== want) begin
						mismatches++;
						if (mismatches <= 10) begin
							$display("result %0d expected: open=%b main=%b amber=%b red=%b move=%b tgt=%0d step=%0d",
								result_idx, want.gate_is_open, want.main_led, want.amber_led,
								want.red_led, want.move_start, want.move_target, want.move_step_ms);
							$display("result %0d actual:   open=%b main=%b amber=%b red=%b move=%b tgt=%0d step=%0d",
								result_idx, got.gate_is_open, got.main_led, got.amber_led,
								got.red_led, got.move_start, got.move_target, got.move_step_ms);
						end
					end
				end
				result_idx++;
			end

			if (cfg_we) begin
				case (cfg_index)
					REG_SOUND_THRESHOLD: regs.sound_threshold = cfg_data[9:0];
					REG_ECHO_LIMIT_US:   regs.echo_limit_us = cfg_data[14:0];
					REG_LOCKOUT_MS:      regs.lockout_ms = cfg_data;
					REG_LED_HOLD_MS:     regs.led_hold_ms = cfg_data;
					REG_BLINK_MS:        regs.blink_ms = cfg_data;
					REG_OPEN_STEP_MS:    regs.open_step_ms = cfg_data[7:0];
					REG_CLOSE_STEP_MS:   regs.close_step_ms = cfg_data[7:0];
					REG_OPEN_ANGLE:      regs.open_angle = cfg_data[7:0];
					default: ;
				endcase
			end

			if (in_valid && !in_stall) begin
				predict_poll(now_ms, mic_sample, echo_us, want);
				expected_results.push_back(want);
			end

			pending = expected_results.size();
		end
	end

endmodule

FILE: tb/sv/tb.sv
// testbench top of the gate sound presence controller: stimulus, stalls and verdict
module tb;
	import gspc_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int N_DIRECTED  = 22;
	localparam int N_PHASES    = 7;
	localparam int PHASE_POLLS = 250;
	localparam int CYCLE_LIMIT = 500000;
	localparam int LONG_HOLD   = 400;
	localparam int HOLD_AT     = 700;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     in_valid = 1'b0;
	logic                     in_stall;
	logic [31:0]              now_ms = '0;
	logic [9:0]               mic_sample = '0;
	logic [14:0]              echo_us = '0;
	logic                     out_valid;
	logic                     out_stall = 1'b0;
	logic                     gate_is_open, main_led, amber_led, red_led, move_start;
	logic [7:0]               move_target, move_step_ms;
	logic                     cfg_we = 1'b0;
	logic [CFG_IDX_BITS-1:0]  cfg_index = REG_SOUND_THRESHOLD;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;

	int mismatches, pending;
	int cycle_count = 0;
	int taken = 0;
	int stall_len;
	bit tx_burst = 1'b0;
	bit rx_burst = 1'b0;

	// stimulus side copy of the settings that shape the polls
	int cur_thr   = int'(RST_SOUND_THRESHOLD);
	int cur_limit = int'(RST_ECHO_LIMIT_US);
	int cur_lock  = int'(RST_LOCKOUT_MS);
	int cur_hold  = int'(RST_LED_HOLD_MS);
	int cur_ostep = int'(RST_OPEN_STEP_MS);
	int cur_angle = int'(RST_OPEN_ANGLE);

	logic [31:0] t_cur;
	int          prev_m;
	logic [31:0] poll_t;
	logic [9:0]  poll_m;
	logic [14:0] poll_e;

	// opening, lockout, closing, hold-off and time wrap at reset settings
	logic [31:0] dir_t [N_DIRECTED] = '{
		32'd0, 32'd10, 32'd20, 32'd3001, 32'd3002, 32'd3003, 32'd3004, 32'd3005,
		32'd3006, 32'd3010, 32'd3020, 32'd7000, 32'd7001, 32'd9637, 32'd9638,
		32'd14637, 32'd14638, 32'hFFFF_F000, 32'hFFFF_FFFF, 32'h0000_0100,
		32'h0000_0E20, 32'h0000_1000};
	logic [9:0] dir_m [N_DIRECTED] = '{
		10'd0, 10'd15, 10'd31, 10'd31, 10'd1023, 10'd1023, 10'd0, 10'd0,
		10'd1023, 10'd0, 10'd0, 10'd600, 10'd600, 10'd0, 10'd0,
		10'd0, 10'd0, 10'd0, 10'd1023, 10'd1023, 10'd0, 10'd0};
	logic [14:0] dir_e [N_DIRECTED] = '{
		15'd0, 15'd1470, 15'd1470, 15'd1, 15'd1471, 15'd1, 15'd30000, 15'd1,
		15'd1, 15'd1, 15'd0, 15'd0, 15'd0, 15'd0, 15'd0,
		15'd0, 15'd0, 15'd0, 15'd1000, 15'd0, 15'd0, 15'd0};

	gate_sound_presence_controller u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.mic_sample   (mic_sample),
		.echo_us      (echo_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gate_is_open (gate_is_open),
		.main_led     (main_led),
		.amber_led    (amber_led),
		.red_led      (red_led),
		.move_start   (move_start),
		.move_target  (move_target),
		.move_step_ms (move_step_ms),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	gspc_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.now_ms       (now_ms),
		.mic_sample   (mic_sample),
		.echo_us      (echo_us),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.gate_is_open (gate_is_open),
		.main_led     (main_led),
		.amber_led    (amber_led),
		.red_led      (red_led),
		.move_start   (move_start),
		.move_target  (move_target),
		.move_step_ms (move_step_ms),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.mismatches   (mismatches),
		.pending      (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("** gate_sound_presence_controller: FAILED **");
			$finish;
		end
	end

	function int sender_gap();
		if ($urandom_range(0, 29) == 0)
			tx_burst = !tx_burst;
		return tx_burst ? 0 : $urandom_range(0, 18);
	endfunction

	// valid stays high across back-to-back polls, only the payload changes
	task offer_poll(input logic [31:0] t, input logic [9:0] m, input logic [14:0] e,
			input int gap);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		now_ms <= t;
		mic_sample <= m;
		echo_us <= e;
		do @(posedge clk); while (in_stall);
	endtask

	task drain_results();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending != 0) @(negedge clk);
	endtask

	task set_reg(input logic [CFG_IDX_BITS-1:0] idx, input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(negedge clk);
		cfg_we <= 1'b0;
		case (idx)
			REG_SOUND_THRESHOLD: cur_thr = int'(data[9:0]);
			REG_ECHO_LIMIT_US:   cur_limit = int'(data[14:0]);
			REG_LOCKOUT_MS:      cur_lock = int'(data);
			REG_LED_HOLD_MS:     cur_hold = int'(data);
			REG_OPEN_STEP_MS:    cur_ostep = int'(data[7:0]);
			REG_OPEN_ANGLE:      cur_angle = int'(data[7:0]);
			default: ;
		endcase
	endtask

	// mode 0 all zero, mode 1 all ones, otherwise random with extremes mixed in
	function logic [CFG_DATA_BITS-1:0] cfg_value(input int mode, input int hi);
		int r;
		if (mode == 0)
			return '0;
		if (mode == 1)
			return '1;
		r = $urandom_range(0, 5);
		if (r == 0)
			return '0;
		if (r == 1)
			return '1;
		return CFG_DATA_BITS'($urandom_range(0, hi));
	endfunction

	task program_regs(input int mode);
		set_reg(REG_SOUND_THRESHOLD, cfg_value(mode, 200));
		set_reg(REG_ECHO_LIMIT_US,   cfg_value(mode, 30000));
		set_reg(REG_LOCKOUT_MS,      cfg_value(mode, 6000));
		set_reg(REG_LED_HOLD_MS,     cfg_value(mode, 8000));
		set_reg(REG_BLINK_MS,        cfg_value(mode, 1000));
		set_reg(REG_OPEN_STEP_MS,    cfg_value(mode, 40));
		set_reg(REG_CLOSE_STEP_MS,   cfg_value(mode, 40));
		set_reg(REG_OPEN_ANGLE,      cfg_value(mode, 180));
	endtask

	// mostly steady time steps on the scale of the lockout, quiet and loud samples
	// alternating, and echoes inside the presence window
	task make_poll(output logic [31:0] t, output logic [9:0] m, output logic [14:0] e);
		int span, r, lim, d;
		span = (cur_lock + cur_angle * cur_ostep + cur_hold) / 6 + 30;
		r = $urandom_range(0, 19);
		if (r == 19)
			t_cur = $urandom();
		else if (r >= 15)
			t_cur = t_cur + $urandom_range(0, 4 * span);
		else if (r >= 2)
			t_cur = t_cur + $urandom_range(0, span);
		t = t_cur;

		r = $urandom_range(0, 9);
		if (r < 4) begin
			m = (prev_m >= 512) ? 10'($urandom_range(0, 100)) : 10'($urandom_range(923, 1023));
		end else if (r == 4) begin
			m = 10'($urandom_range(0, 1023));
		end else begin
			d = $urandom_range(0, (cur_thr > 4) ? 4 : cur_thr);
			m = (prev_m >= 512) ? 10'(prev_m - d) : 10'(prev_m + d);
		end
		prev_m = int'(m);

		lim = (cur_limit > 30000) ? 30000 : cur_limit;
		r = $urandom_range(0, 19);
		if (r < 12 && lim > 0)
			e = 15'($urandom_range(1, lim));
		else if (r < 15)
			e = '0;
		else if (r < 17)
			e = (lim < 30000) ? 15'(lim + 1) : 15'(lim);
		else
			e = 15'($urandom_range(0, 30000));
	endtask

	// result side: per-transaction stall, one long hold-off to back up the block
	initial begin
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 29) == 0)
				rx_burst = !rx_burst;
			if (taken == HOLD_AT)
				stall_len = LONG_HOLD;
			else
				stall_len = rx_burst ? 0 : $urandom_range(0, 18);
			@(negedge clk);
			if (stall_len > 0) begin
				out_stall <= 1'b1;
				repeat (stall_len) @(negedge clk);
				out_stall <= 1'b0;
			end
			do @(posedge clk); while (!(out_valid && !out_stall));
			taken++;
		end
	end

	initial begin
		repeat (4) @(negedge clk);
		arst_n <= 1'b1;

		for (int i = 0; i < N_DIRECTED; i++)
			offer_poll(dir_t[i], dir_m[i], dir_e[i], sender_gap());

		t_cur = 32'h0000_2000;
		prev_m = 0;
		for (int p = 0; p < N_PHASES; p++) begin
			if (p > 0) begin
				drain_results();
				repeat (4) @(negedge clk);
				program_regs((p == 1) ? 0 : (p == 2) ? 1 : 2);
				if (p == 3)
					t_cur = 32'hFFFF_FFFF - $urandom_range(0, 20000);
			end
			for (int i = 0; i < PHASE_POLLS; i++) begin
				make_poll(poll_t, poll_m, poll_e);
				offer_poll(poll_t, poll_m, poll_e, sender_gap());
			end
		end

		drain_results();
		repeat (10) @(negedge clk);
		if (mismatches == 0)
			$display("** gate_sound_presence_controller: PASSED **");
		else
			$display("** gate_sound_presence_controller: FAILED **");
		$finish;
	end

endmodule

FILE: gate_sound_presence_controller.f
hdl/gspc_pkg.sv
hdl/gspc_cfg_regs.sv
hdl/gspc_core.sv
hdl/gate_sound_presence_controller.sv
tb/sv/gspc_checker.sv
tb/sv/tb.sv
